### design/spg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_pkg : shared types and constants of the stereo pan gain block
// Fixed-point formats, pan law codes, the tag that travels with a beat
// through the pipeline and the stage counts that set the latency.
// ----------------------------------------------------------------------------
package spg_pkg;

   // Internal gains are Q1.30, held in 31 bits (full scale 1.0 included)
   localparam int unsigned SPG_Q_BITS     = 30;
   localparam logic [30:0] SPG_Q_ONE      = 31'h4000_0000;
   localparam logic [30:0] SPG_HALF_PI    = 31'd1686629713;

   // Sine series: odd powers up to the 21st, i.e. ten correction terms
   localparam int unsigned SPG_NUM_TERMS  = 10;
   // Root of a Q60 product: one result bit per step
   localparam int unsigned SPG_ROOT_STEPS = 31;

   // Pipeline depth of each unit and of the whole block
   localparam int unsigned SPG_SINE_STAGES = 3 + 3 * SPG_NUM_TERMS;
   localparam int unsigned SPG_ROOT_STAGES = 1 + SPG_ROOT_STEPS;
   localparam int unsigned SPG_LATENCY     = 2 + SPG_SINE_STAGES + SPG_ROOT_STAGES;

   typedef enum logic [1:0] {
      SPG_LAW_LINEAR     = 2'd0,
      SPG_LAW_POWER      = 2'd1,
      SPG_LAW_COMPROMISE = 2'd2,
      SPG_LAW_LINEAR_ALT = 2'd3
   } spg_law_type;

   // Law and linear share of one channel, carried alongside each beat
   typedef struct packed {
      spg_law_type law;
      logic [30:0] lin;
   } spg_tag_type;

   // Divisor of the k-th series term: (2k)(2k+1)
   function automatic int unsigned spg_divisor(input int unsigned k);
      return (2 * k) * (2 * k + 1);
   endfunction

endpackage

### design/spg_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_sine : pipelined quarter sine, sin(x * pi/2) in Q30
// Scales the angle, squares it, then forms each Taylor term in three
// stages (multiply by theta squared, multiply by reciprocal, correct the
// quotient) and folds it into the running sum one term later.
// ----------------------------------------------------------------------------
module spg_sine
   import spg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  spg_tag_type in_tag,
   output logic        out_valid,
   output logic [30:0] out_sine,
   output spg_tag_type out_tag
);

   localparam int unsigned NT = SPG_NUM_TERMS;

   typedef struct packed {
      logic        zero;
      logic        full;
      spg_tag_type tag;
   } sine_meta_type;

   // Stage 1: angle scaling
   logic          s1_valid_ff;
   sine_meta_type s1_meta_ff, s1_meta_in;
   logic [30:0]   s1_theta_ff, s1_theta_in;
   logic [61:0]   s1_prod;

   // Term pipeline; index 0 holds the squared angle stage
   logic          c_valid_ff [0:NT];
   sine_meta_type c_meta_ff  [0:NT];
   logic [31:0]   c_t2_ff    [0:NT];
   logic [31:0]   c_sum_ff   [0:NT];
   logic [30:0]   c_term_ff  [0:NT];
   logic [63:0]   s2_sq;

   logic          a_valid_ff [1:NT];
   sine_meta_type a_meta_ff  [1:NT];
   logic [31:0]   a_t2_ff    [1:NT];
   logic [31:0]   a_sum_ff   [1:NT];
   logic [62:0]   a_prod_ff  [1:NT];

   logic          b_valid_ff [1:NT];
   sine_meta_type b_meta_ff  [1:NT];
   logic [31:0]   b_t2_ff    [1:NT];
   logic [31:0]   b_sum_ff   [1:NT];
   logic [32:0]   b_v_ff     [1:NT];
   logic [62:0]   b_qm_ff    [1:NT];

   // Final stage
   logic          f_valid_ff;
   logic [30:0]   f_sine_ff, f_sine_in;
   spg_tag_type   f_tag_ff;
   logic [31:0]   f_sum;

   // Scale the linear share by pi/2 and flag the exact end points
   assign s1_prod     = 62'(in_tag.lin) * 62'(SPG_HALF_PI);
   assign s1_theta_in = 31'(s1_prod >> SPG_Q_BITS);
   assign s1_meta_in  = '{zero: (in_tag.lin == '0),
                          full: (in_tag.lin >= SPG_Q_ONE),
                          tag:  in_tag};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff  <= s1_meta_in;
      s1_theta_ff <= s1_theta_in;
   end

   // Square the angle and seed the series with theta
   assign s2_sq = 64'(s1_theta_ff) * 64'(s1_theta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff[0] <= 1'b0;
      end else begin
         c_valid_ff[0] <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_meta_ff[0] <= s1_meta_ff;
      c_t2_ff[0]   <= 32'(s2_sq >> SPG_Q_BITS);
      c_sum_ff[0]  <= 32'(s1_theta_ff);
      c_term_ff[0] <= s1_theta_ff;
   end

   // One block of three stages per series term
   for (genvar k = 1; k <= NT; k++) begin : g_term
      localparam int unsigned DIV_N = spg_divisor(k);
      localparam logic [63:0] DIV_W = 64'(DIV_N);
      localparam logic [29:0] RECIP = 30'((64'd1 << 32) / DIV_W);

      logic [31:0] sum_in;
      logic [62:0] prod_in;
      logic [32:0] v_in;
      logic [62:0] qm_in;
      logic [30:0] qp;
      logic [40:0] rem;
      logic [30:0] term_in;

      // Fold the previous term into the sum: odd terms subtract, even add
      if (k == 1) begin : g_seed
         assign sum_in = c_sum_ff[k-1];
      end else if ((k % 2) == 0) begin : g_sub
         assign sum_in = (c_sum_ff[k-1] >= 32'(c_term_ff[k-1])) ?
                         c_sum_ff[k-1] - 32'(c_term_ff[k-1]) : '0;
      end else begin : g_add
         assign sum_in = c_sum_ff[k-1] + 32'(c_term_ff[k-1]);
      end

      // Stage A: previous term times theta squared
      assign prod_in = 63'(c_term_ff[k-1]) * 63'(c_t2_ff[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[k] <= 1'b0;
         end else begin
            a_valid_ff[k] <= c_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         a_meta_ff[k] <= c_meta_ff[k-1];
         a_t2_ff[k]   <= c_t2_ff[k-1];
         a_sum_ff[k]  <= sum_in;
         a_prod_ff[k] <= prod_in;
      end

      // Stage B: estimate the quotient with a truncated reciprocal
      assign v_in  = 33'(a_prod_ff[k] >> SPG_Q_BITS);
      assign qm_in = 63'(v_in) * 63'(RECIP);

      always_ff @(posedge clock) begin
         if (reset) begin
            b_valid_ff[k] <= 1'b0;
         end else begin
            b_valid_ff[k] <= a_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         b_meta_ff[k] <= a_meta_ff[k];
         b_t2_ff[k]   <= a_t2_ff[k];
         b_sum_ff[k]  <= a_sum_ff[k];
         b_v_ff[k]    <= v_in;
         b_qm_ff[k]   <= qm_in;
      end

      // Stage C: the estimate is low by at most two; correct from the remainder
      assign qp      = 31'(b_qm_ff[k] >> 32);
      assign rem     = 41'(b_v_ff[k]) - 41'(qp) * 41'(DIV_N);
      assign term_in = qp + 31'(rem >= 41'(DIV_N)) + 31'(rem >= 41'(2 * DIV_N));

      always_ff @(posedge clock) begin
         if (reset) begin
            c_valid_ff[k] <= 1'b0;
         end else begin
            c_valid_ff[k] <= b_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         c_meta_ff[k] <= b_meta_ff[k];
         c_t2_ff[k]   <= b_t2_ff[k];
         c_sum_ff[k]  <= b_sum_ff[k];
         c_term_ff[k] <= term_in;
      end
   end

   // Fold the last term, then clamp and apply the exact end points
   if ((NT % 2) == 0) begin : g_last_add
      assign f_sum = c_sum_ff[NT] + 32'(c_term_ff[NT]);
   end else begin : g_last_sub
      assign f_sum = (c_sum_ff[NT] >= 32'(c_term_ff[NT])) ?
                     c_sum_ff[NT] - 32'(c_term_ff[NT]) : '0;
   end

   always_comb begin
      if (c_meta_ff[NT].zero) begin
         f_sine_in = '0;
      end else if (c_meta_ff[NT].full || (f_sum > 32'(SPG_Q_ONE))) begin
         f_sine_in = SPG_Q_ONE;
      end else begin
         f_sine_in = 31'(f_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= c_valid_ff[NT];
      end
   end

   always_ff @(posedge clock) begin
      f_sine_ff <= f_sine_in;
      f_tag_ff  <= c_meta_ff[NT].tag;
   end

   assign out_valid = f_valid_ff;
   assign out_sine  = f_sine_ff;
   assign out_tag   = f_tag_ff;

endmodule

### design/spg_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_isqrt : pipelined integer square root of linear share times sine
// Forms the Q60 product, then settles one root bit per stage with a
// restoring compare and subtract. The sine travels alongside the beat.
// ----------------------------------------------------------------------------
module spg_isqrt
   import spg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [30:0] in_sine,
   input  spg_tag_type in_tag,
   output logic        out_valid,
   output logic [30:0] out_root,
   output logic [30:0] out_sine,
   output spg_tag_type out_tag
);

   localparam int unsigned NS = SPG_ROOT_STEPS;

   logic        r_valid_ff [0:NS];
   logic [60:0] r_rem_ff   [0:NS];
   logic [61:0] r_root_ff  [0:NS];
   logic [30:0] r_sine_ff  [0:NS];
   spg_tag_type r_tag_ff   [0:NS];
   logic [61:0] prod;

   // Stage 0: product of the linear share and the sine
   assign prod = 62'(in_tag.lin) * 62'(in_sine);

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff[0] <= 1'b0;
      end else begin
         r_valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      r_rem_ff[0]  <= 61'(prod);
      r_root_ff[0] <= '0;
      r_sine_ff[0] <= in_sine;
      r_tag_ff[0]  <= in_tag;
   end

   // One root bit per stage, highest first
   for (genvar i = 0; i < NS; i++) begin : g_step
      localparam logic [61:0] BIT = 62'(1) << (2 * (NS - 1 - i));

      logic [61:0] trial;
      logic [60:0] rem_in;
      logic [61:0] root_in;

      assign trial = r_root_ff[i] + BIT;

      always_comb begin
         if (62'(r_rem_ff[i]) >= trial) begin
            rem_in  = 61'(62'(r_rem_ff[i]) - trial);
            root_in = (r_root_ff[i] >> 1) + BIT;
         end else begin
            rem_in  = r_rem_ff[i];
            root_in = r_root_ff[i] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            r_valid_ff[i+1] <= 1'b0;
         end else begin
            r_valid_ff[i+1] <= r_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         r_rem_ff[i+1]  <= rem_in;
         r_root_ff[i+1] <= root_in;
         r_sine_ff[i+1] <= r_sine_ff[i];
         r_tag_ff[i+1]  <= r_tag_ff[i];
      end
   end

   assign out_valid = r_valid_ff[NS];
   assign out_root  = 31'(r_root_ff[NS]);
   assign out_sine  = r_sine_ff[NS];
   assign out_tag   = r_tag_ff[NS];

endmodule

### design/spg_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_lane : gain path of one stereo channel
// Runs the quarter sine and the square root pipelines back to back and
// picks the gain that the beat's pan law asks for, truncated to the output
// format.
// ----------------------------------------------------------------------------
module spg_lane
   import spg_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  spg_tag_type in_tag,
   output logic        out_valid,
   output logic [15:0] out_gain
);

   logic        sine_valid;
   logic [30:0] sine_value;
   spg_tag_type sine_tag;

   logic        root_valid;
   logic [30:0] root_value;
   logic [30:0] root_sine;
   spg_tag_type root_tag;

   logic [30:0] gain_q30;

   spg_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_tag    (in_tag),
      .out_valid (sine_valid),
      .out_sine  (sine_value),
      .out_tag   (sine_tag)
   );

   spg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sine_valid),
      .in_sine   (sine_value),
      .in_tag    (sine_tag),
      .out_valid (root_valid),
      .out_root  (root_value),
      .out_sine  (root_sine),
      .out_tag   (root_tag)
   );

   // Select the gain for the law; unused law codes fall back to linear
   always_comb begin
      unique case (root_tag.law)
         SPG_LAW_POWER: begin
            gain_q30 = root_sine;
         end
         SPG_LAW_COMPROMISE: begin
            gain_q30 = (root_value > SPG_Q_ONE) ? SPG_Q_ONE : root_value;
         end
         default: begin
            gain_q30 = root_tag.lin;
         end
      endcase
   end

   assign out_valid = root_valid;
   assign out_gain  = 16'(gain_q30 >> (SPG_Q_BITS - FRACTION_BITS));

endmodule

### design/stereo_pan_gain_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_pan_gain_top : left and right gains for a stereo pan position
// Pan position in, linear / constant-power / compromise gain pair out.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive req_pan_position and raise start; the beat is taken at a
//   clock edge where start is high and busy is low. busy never rises, so a
//   new pan position may be presented in every cycle.
//   Output: each result appears on rsp_left_gain / rsp_right_gain for one
//   cycle with rsp_strobe high, in order of acceptance, after the beat has
//   crossed the input register, the 33-stage sine pipeline (angle scaling,
//   squaring, three stages per series term, final sum), the 32-stage square
//   root pipeline and the output register.
//   Throughput: one beat per cycle, whatever the pan law.
//   Configuration: csr_pan_law is written when csr_valid is high (csr_ready
//   is always high). Write it only with no beat in flight; each beat keeps
//   the law that was set when it was accepted.
//   Reset: synchronous, clears all valid bits and sets the law to linear;
//   no strobe appears until a new beat has crossed the pipeline.
//   The receiver cannot stall: results are never held and never dropped.
// ----------------------------------------------------------------------------
module stereo_pan_gain_top
   import spg_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_pan_position,
   output logic        rsp_strobe,
   output logic [15:0] rsp_left_gain,
   output logic [15:0] rsp_right_gain,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_pan_law
);

   localparam int unsigned SAT_W = (FRACTION_BITS + 1 > 16) ? FRACTION_BITS + 1 : 16;
   localparam logic [SAT_W-1:0] PAN_ONE = SAT_W'(1) << FRACTION_BITS;

   logic             accept;
   spg_law_type      law_ff, law_in;
   logic [SAT_W-1:0] pan_ext;
   logic [SAT_W-1:0] pan_sat;
   logic [30:0]      xr_in;
   logic [30:0]      xl_in;

   logic             in_valid_ff;
   spg_tag_type      left_tag_ff, left_tag_in;
   spg_tag_type      right_tag_ff, right_tag_in;

   logic             left_valid;
   logic [15:0]      left_gain;
   logic             right_valid;
   logic [15:0]      right_gain;

   logic             rsp_strobe_ff;
   logic [15:0]      rsp_left_ff;
   logic [15:0]      rsp_right_ff;

   // The pipeline never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // Hold the pan law register
   assign law_in = spg_law_type'(csr_pan_law);

   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff <= SPG_LAW_LINEAR;
      end else if (csr_valid && csr_ready) begin
         law_ff <= law_in;
      end
   end

   // Saturate the pan to hard right and split it into Q30 shares
   assign pan_ext = SAT_W'(req_pan_position);
   assign pan_sat = (pan_ext > PAN_ONE) ? PAN_ONE : pan_ext;
   assign xr_in   = 31'(pan_sat) << (SPG_Q_BITS - FRACTION_BITS);
   assign xl_in   = SPG_Q_ONE - xr_in;

   assign left_tag_in  = '{law: law_ff, lin: xl_in};
   assign right_tag_in = '{law: law_ff, lin: xr_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      left_tag_ff  <= left_tag_in;
      right_tag_ff <= right_tag_in;
   end

   spg_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_left (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_tag    (left_tag_ff),
      .out_valid (left_valid),
      .out_gain  (left_gain)
   );

   spg_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_tag    (right_tag_ff),
      .out_valid (right_valid),
      .out_gain  (right_gain)
   );

   // Register the result beat for its single strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= left_valid & right_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_left_ff  <= left_gain;
      rsp_right_ff <= right_gain;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_left_gain  = rsp_left_ff;
   assign rsp_right_gain = rsp_right_ff;

endmodule

### design/spg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_checker : port-level checks of the stereo pan gain block
// Tracks the pan law from the configuration port and checks result timing,
// gain range and the linear law's gain sum on the top level's ports.
// ----------------------------------------------------------------------------
module spg_checker
   import spg_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 15
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [15:0] req_pan_position,
   input logic        rsp_strobe,
   input logic [15:0] rsp_left_gain,
   input logic [15:0] rsp_right_gain,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_pan_law
);

   spg_law_type law_ff, law_in;
   logic        pan_legal;

   // Mirror the law register
   assign law_in    = spg_law_type'(csr_pan_law);
   assign pan_legal = (req_pan_position != '1) || (FRACTION_BITS > 15);

   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff <= SPG_LAW_LINEAR;
      end else if (csr_valid && csr_ready) begin
         law_ff <= law_in;
      end
   end

   // Expect no strobe in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // Every result beat comes from a beat accepted a fixed latency earlier
   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, SPG_LATENCY))
      else $error("result strobe without a matching input beat");

   if (FRACTION_BITS <= 15) begin : g_narrow
      localparam logic [16:0] ONE = 17'(1) << FRACTION_BITS;

      // Gains never exceed full scale
      a_gain_range: assert property (@(posedge clock) disable iff (reset)
         rsp_strobe |-> (17'(rsp_left_gain) <= ONE) && (17'(rsp_right_gain) <= ONE))
         else $error("gain above full scale");

      // Linear law: the two gains add up to full scale exactly
      a_linear_sum: assert property (@(posedge clock) disable iff (reset)
         rsp_strobe && pan_legal &&
         ((law_ff == SPG_LAW_LINEAR) || (law_ff == SPG_LAW_LINEAR_ALT))
         |-> (17'(rsp_left_gain) + 17'(rsp_right_gain) == ONE))
         else $error("linear gains do not sum to full scale");
   end

endmodule

bind stereo_pan_gain_top spg_checker #(
   .FRACTION_BITS (FRACTION_BITS)
) u_spg_checker (.*);
